>>> design/abvad_pkg.sv
// shared types and constants of the voice activity detector
`timescale 1ns / 1ps

package abvad_pkg;

    // accumulator widths, sized for the largest block length
    localparam int CNT_W     = 17;
    localparam int SQ_W      = 48;
    localparam int TERM_W    = 19;
    localparam int BAND_W    = 36;
    localparam int DIV_A_W   = 64;
    localparam int DIV_B_W   = 36;
    localparam int DIV_CNT_W = 7;
    localparam int OUT_W     = 136;

    // fixed point constants, q31 unless noted
    localparam logic [31:0] FLOOR_MIN    = 32'h0010_0000;
    localparam logic [31:0] Q31_ONE      = 32'h8000_0000;
    localparam logic [35:0] DENOM_BIAS   = 36'd21474836;
    localparam logic [31:0] OPEN_THRESH  = 32'd1181116006;
    localparam logic [31:0] CLOSE_THRESH = 32'd644245094;
    localparam logic [15:0] Q15_ONE      = 16'd32768;
    localparam logic [19:0] LEVEL_WEIGHT = 20'd229376;
    // ceil(2^20 / 5), exact floor quotient for dividends below 2^18
    localparam logic [17:0] P_RECIP      = 18'd209716;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LOW_SPLIT    = 3'd0,
        CFG_MID_SPLIT    = 3'd1,
        CFG_FAST_ATTACK  = 3'd2,
        CFG_FAST_RELEASE = 3'd3,
        CFG_SLOW_ATTACK  = 3'd4,
        CFG_SLOW_RELEASE = 3'd5,
        CFG_FLOOR_FALL   = 3'd6,
        CFG_FLOOR_RISE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] low_split_coef;
        logic [15:0] mid_split_coef;
        logic [15:0] fast_attack;
        logic [15:0] fast_release;
        logic [15:0] slow_attack;
        logic [15:0] slow_release;
        logic [15:0] floor_fall_rate;
        logic [15:0] floor_rise_rate;
    } cfg_t;

    // per-block totals handed from front to back
    typedef struct packed {
        logic [SQ_W-1:0]   square_sum;
        logic [15:0]       peak;
        logic [BAND_W-1:0] low_sum;
        logic [BAND_W-1:0] mid_sum;
        logic [BAND_W-1:0] high_sum;
        logic [CNT_W-1:0]  count;
    } block_t;

    // result transaction, last field in the lowest bits
    typedef struct packed {
        logic        voice_active;
        logic [15:0] voice_probability;
        logic [15:0] noise_floor_level;
        logic [15:0] high_band_level;
        logic [15:0] mid_band_level;
        logic [15:0] low_band_level;
        logic [15:0] transient_level;
        logic [15:0] peak_level;
        logic [15:0] rms_level;
    } result_t;

endpackage

>>> design/abvad_front.sv
// sample front end: band split filters and per-block accumulation
`timescale 1ns / 1ps

module abvad_front
    import abvad_pkg::*;
#(
    parameter int BLOCK_MAX = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_sample,
    input  logic        in_last,
    input  logic        q_full,
    output logic        q_push,
    output block_t      q_data
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_FILT = 4'b0010,
        F_BAND = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic signed [15:0] x_reg;
    logic               last_reg;
    logic signed [33:0] low_reg, low_next;
    logic signed [33:0] mid_reg, mid_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [15:0]        peak_reg, peak_next;
    logic [BAND_W-1:0]  lsum_reg, lsum_next;
    logic [BAND_W-1:0]  msum_reg, msum_next;
    logic [BAND_W-1:0]  hsum_reg, hsum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic signed [34:0] xs, low_ext, mid_ext;
    logic signed [34:0] low_diff, mid_diff;
    logic signed [51:0] low_prod, mid_prod;
    logic [35:0]        low_sum36, mid_sum36;
    logic [15:0]        ax;
    logic [31:0]        ax_sq;
    logic [TERM_W-1:0]  low_term, mid_term, high_term;

    // magnitude rounded half up to whole sample units
    function automatic logic [TERM_W-1:0] mag_units(input logic signed [34:0] v);
        logic [34:0] a;
        logic [35:0] s;
        a = v[34] ? 35'(-v) : 35'(v);
        s = {1'b0, a} + 36'd32768;
        return s[TERM_W+15:16];
    endfunction

    assign in_ready = (state_reg == F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_data   = '{square_sum: sq_reg, peak: peak_reg, low_sum: lsum_reg,
                        mid_sum: msum_reg, high_sum: hsum_reg, count: cnt_reg};

    // filter updates, one multiplier per filter
    always_comb
    begin
        xs        = {{3{x_reg[15]}}, x_reg, 16'b0};
        low_ext   = {low_reg[33], low_reg};
        mid_ext   = {mid_reg[33], mid_reg};
        low_diff  = xs - low_ext;
        mid_diff  = xs - mid_ext;
        low_prod  = $signed({1'b0, cfg.low_split_coef}) * low_diff;
        mid_prod  = $signed({1'b0, cfg.mid_split_coef}) * mid_diff;
        low_sum36 = {{2{low_reg[33]}}, low_reg} + low_prod[51:16];
        mid_sum36 = {{2{mid_reg[33]}}, mid_reg} + mid_prod[51:16];
        ax        = x_reg[15] ? 16'(-x_reg) : 16'(x_reg);
        ax_sq     = ax * ax;
        low_term  = mag_units(low_ext);
        mid_term  = mag_units(mid_ext - low_ext);
        high_term = mag_units(xs - mid_ext);
    end

    // sequencer and accumulators
    always_comb
    begin
        state_next = state_reg;
        low_next   = low_reg;
        mid_next   = mid_reg;
        sq_next    = sq_reg;
        peak_next  = peak_reg;
        lsum_next  = lsum_reg;
        msum_next  = msum_reg;
        hsum_next  = hsum_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_FILT;
                end
            end
            F_FILT:
            begin
                low_next   = low_sum36[33:0];
                mid_next   = mid_sum36[33:0];
                state_next = F_BAND;
            end
            F_BAND:
            begin
                if (cnt_reg < CNT_W'(BLOCK_MAX))
                begin
                    sq_next   = sq_reg + SQ_W'(ax_sq);
                    peak_next = (ax > peak_reg) ? ax : peak_reg;
                    lsum_next = lsum_reg + BAND_W'(low_term);
                    msum_next = msum_reg + BAND_W'(mid_term);
                    hsum_next = hsum_reg + BAND_W'(high_term);
                    cnt_next  = cnt_reg + 1'b1;
                end
                state_next = last_reg ? F_PUSH : F_IDLE;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    sq_next    = '0;
                    peak_next  = '0;
                    lsum_next  = '0;
                    msum_next  = '0;
                    hsum_next  = '0;
                    cnt_next   = '0;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            low_reg   <= '0;
            mid_reg   <= '0;
            sq_reg    <= '0;
            peak_reg  <= '0;
            lsum_reg  <= '0;
            msum_reg  <= '0;
            hsum_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            mid_reg   <= mid_next;
            sq_reg    <= sq_next;
            peak_reg  <= peak_next;
            lsum_reg  <= lsum_next;
            msum_reg  <= msum_next;
            hsum_reg  <= hsum_next;
            cnt_reg   <= cnt_next;
        end
    end

    // sample capture on each input transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg    <= $signed(in_sample);
            last_reg <= in_last;
        end
    end

endmodule

>>> design/abvad_queue.sv
// two-entry queue of block totals between front and back
`timescale 1ns / 1ps

module abvad_queue
    import abvad_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  block_t push_data,
    output logic   full,
    input  logic   pop,
    output block_t pop_data,
    output logic   empty
);

    block_t      mem [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/abvad_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module abvad_div
    import abvad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_A_W-1:0] dividend,
    input  logic [DIV_B_W-1:0] divisor,
    output logic               done,
    output logic [DIV_A_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_B_W:0]     rem_reg;
    logic [DIV_A_W-1:0]   quo_reg;
    logic [DIV_B_W-1:0]   den_reg;
    logic [DIV_B_W:0]     shifted;
    logic                 fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        shifted = {rem_reg[DIV_B_W-1:0], quo_reg[DIV_A_W-1]};
        fits    = (shifted >= {1'b0, den_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_A_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - {1'b0, den_reg}) : shifted;
            quo_reg <= {quo_reg[DIV_A_W-2:0], fits};
        end
    end

endmodule

>>> design/abvad_back.sv
// block back end: means, root, envelopes, floor, probability, hysteresis
`timescale 1ns / 1ps

module abvad_back
    import abvad_pkg::*;
#(
    parameter int OPEN_BLOCKS  = 3,
    parameter int CLOSE_BLOCKS = 10
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_empty,
    output logic    q_pop,
    input  block_t  q_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_DSQ    = 16'h0002,
        ST_SQRT   = 16'h0004,
        ST_DLOW   = 16'h0008,
        ST_DMID   = 16'h0010,
        ST_DHIGH  = 16'h0020,
        ST_FAST   = 16'h0040,
        ST_SLOW   = 16'h0080,
        ST_FLOOR  = 16'h0100,
        ST_CALC   = 16'h0200,
        ST_DLEVEL = 16'h0400,
        ST_BAND   = 16'h0800,
        ST_DBAND  = 16'h1000,
        ST_MULP   = 16'h2000,
        ST_DP     = 16'h4000,
        ST_FIN    = 16'h8000
    } bstate_t;

    bstate_t            state_reg, state_next;
    block_t             snap_reg, snap_next;
    logic               go_reg, go_next;
    logic [DIV_A_W-1:0] da_reg, da_next;
    logic [DIV_B_W-1:0] db_reg, db_next;
    logic [30:0]        sv_reg, sv_next;
    logic [31:0]        sr_reg, sr_next;
    logic [30:0]        sbit_reg, sbit_next;
    logic [15:0]        rms_reg, rms_next;
    logic [15:0]        lowm_reg, lowm_next;
    logic [15:0]        midm_reg, midm_next;
    logic [15:0]        highm_reg, highm_next;
    logic [15:0]        trans_reg, trans_next;
    logic [15:0]        lp_reg, lp_next;
    logic [15:0]        bp_reg, bp_next;
    logic [15:0]        p_reg, p_next;
    logic [31:0]        fast_reg, fast_next;
    logic [31:0]        slow_reg, slow_next;
    logic [31:0]        floor_reg, floor_next;
    logic [31:0]        prob_reg, prob_next;
    logic [7:0]         open_reg, open_next;
    logic [7:0]         close_reg, close_next;
    logic               active_reg, active_next;
    logic               ov_reg, ov_next;
    result_t            od_reg, od_next;

    logic               div_done;
    logic [DIV_A_W-1:0] div_q;

    logic [31:0]        r_q31;
    logic [31:0]        sq_try;
    logic [31:0]        floor_raw;
    logic signed [37:0] tdiff;
    logic [33:0]        tcl;
    logic [34:0]        t3;
    logic [33:0]        t3c;
    logic [34:0]        tround;
    logic signed [35:0] margin;
    logic [35:0]        denom;
    logic [19:0]        pfactor;
    logic [35:0]        pprod;
    logic [37:0]        pscaled;
    logic [32:0]        vsum;
    logic [31:0]        vnew;
    logic [31:0]        fround, vround;

    // cur + floor(rate * (target - cur) / 65536)
    function automatic logic [31:0] approach(input logic [31:0] cur, input logic [31:0] tgt,
                                             input logic [15:0] rate);
        logic signed [33:0] d;
        logic signed [50:0] pr;
        logic [34:0]        s;
        d  = $signed({2'b0, tgt}) - $signed({2'b0, cur});
        pr = $signed({1'b0, rate}) * d;
        s  = {3'b0, cur} + pr[50:16];
        return s[31:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [DIV_A_W-1:0] v);
        return (v > DIV_A_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
    endfunction

    abvad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg),
        .dividend (da_reg),
        .divisor  (db_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // arithmetic shared by the sequencer steps
    always_comb
    begin
        r_q31     = {rms_reg, 16'b0};
        sq_try    = sr_reg + {1'b0, sbit_reg};
        floor_raw = approach(floor_reg, r_q31,
                             (r_q31 < floor_reg) ? cfg.floor_fall_rate : cfg.floor_rise_rate);
        tdiff     = $signed({4'b0, fast_reg, 2'b0}) -
                    $signed({6'b0, slow_reg} + {4'b0, slow_reg, 2'b0});
        if (tdiff < 0)
        begin
            tcl = '0;
        end
        else if (tdiff > 38'sh2_0000_0000)
        begin
            tcl = 34'h2_0000_0000;
        end
        else
        begin
            tcl = tdiff[33:0];
        end
        t3      = {tcl, 1'b0} + {1'b0, tcl};
        t3c     = (t3 > 35'h2_0000_0000) ? 34'h2_0000_0000 : t3[33:0];
        tround  = {1'b0, t3c} + 35'd131072;
        margin  = $signed({4'b0, r_q31}) - $signed({3'b0, floor_reg, 1'b0} + {4'b0, floor_reg});
        denom   = {2'b0, floor_reg, 2'b0} + {3'b0, floor_reg, 1'b0} + DENOM_BIAS;
        pfactor = LEVEL_WEIGHT + {3'b0, bp_reg, 1'b0} + {4'b0, bp_reg};
        pprod   = lp_reg * pfactor;
        // divide by 327680: drop 16 bits, then multiply by the reciprocal of 5
        pscaled = da_reg[35:16] * P_RECIP;
        vsum    = {1'b0, prob_reg} + {1'b0, p_reg, 16'b0};
        vnew    = vsum[32:1];
        fround  = floor_reg + 32'd32768;
        vround  = vnew + 32'd32768;
    end

    // block sequencer
    always_comb
    begin
        state_next  = state_reg;
        snap_next   = snap_reg;
        go_next     = 1'b0;
        da_next     = da_reg;
        db_next     = db_reg;
        sv_next     = sv_reg;
        sr_next     = sr_reg;
        sbit_next   = sbit_reg;
        rms_next    = rms_reg;
        lowm_next   = lowm_reg;
        midm_next   = midm_reg;
        highm_next  = highm_reg;
        trans_next  = trans_reg;
        lp_next     = lp_reg;
        bp_next     = bp_reg;
        p_next      = p_reg;
        fast_next   = fast_reg;
        slow_next   = slow_reg;
        floor_next  = floor_reg;
        prob_next   = prob_reg;
        open_next   = open_reg;
        close_next  = close_reg;
        active_next = active_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    snap_next  = q_data;
                    go_next    = 1'b1;
                    da_next    = DIV_A_W'(q_data.square_sum);
                    db_next    = DIV_B_W'(q_data.count);
                    state_next = ST_DSQ;
                end
            end
            ST_DSQ:
            begin
                if (div_done)
                begin
                    sv_next    = div_q[30:0];
                    sr_next    = '0;
                    sbit_next  = 31'h4000_0000;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // one root bit per cycle
                if ({1'b0, sv_reg} >= sq_try)
                begin
                    sv_next = sv_reg - sq_try[30:0];
                    sr_next = (sr_reg >> 1) + {1'b0, sbit_reg};
                end
                else
                begin
                    sr_next = sr_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
                if (sbit_reg == 31'd1)
                begin
                    rms_next   = sr_next[15:0];
                    go_next    = 1'b1;
                    da_next    = DIV_A_W'(snap_reg.low_sum);
                    db_next    = DIV_B_W'(snap_reg.count);
                    state_next = ST_DLOW;
                end
            end
            ST_DLOW:
            begin
                if (div_done)
                begin
                    lowm_next  = sat16(div_q);
                    go_next    = 1'b1;
                    da_next    = DIV_A_W'(snap_reg.mid_sum);
                    state_next = ST_DMID;
                end
            end
            ST_DMID:
            begin
                if (div_done)
                begin
                    midm_next  = sat16(div_q);
                    go_next    = 1'b1;
                    da_next    = DIV_A_W'(snap_reg.high_sum);
                    state_next = ST_DHIGH;
                end
            end
            ST_DHIGH:
            begin
                if (div_done)
                begin
                    highm_next = sat16(div_q);
                    state_next = ST_FAST;
                end
            end
            ST_FAST:
            begin
                fast_next  = approach(fast_reg, r_q31,
                                      (r_q31 > fast_reg) ? cfg.fast_attack : cfg.fast_release);
                state_next = ST_SLOW;
            end
            ST_SLOW:
            begin
                slow_next  = approach(slow_reg, r_q31,
                                      (r_q31 > slow_reg) ? cfg.slow_attack : cfg.slow_release);
                state_next = ST_FLOOR;
            end
            ST_FLOOR:
            begin
                if (floor_raw < FLOOR_MIN)
                begin
                    floor_next = FLOOR_MIN;
                end
                else if (floor_raw > Q31_ONE)
                begin
                    floor_next = Q31_ONE;
                end
                else
                begin
                    floor_next = floor_raw;
                end
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                trans_next = tround[33:18];
                if (margin <= 0)
                begin
                    lp_next    = '0;
                    state_next = ST_BAND;
                end
                else if (margin[35:0] >= denom)
                begin
                    lp_next    = Q15_ONE;
                    state_next = ST_BAND;
                end
                else
                begin
                    go_next    = 1'b1;
                    da_next    = DIV_A_W'({margin[35:0], 15'b0});
                    db_next    = denom;
                    state_next = ST_DLEVEL;
                end
            end
            ST_DLEVEL:
            begin
                if (div_done)
                begin
                    lp_next    = div_q[15:0];
                    state_next = ST_BAND;
                end
            end
            ST_BAND:
            begin
                if (rms_reg == '0)
                begin
                    bp_next    = '0;
                    state_next = ST_MULP;
                end
                else
                begin
                    go_next    = 1'b1;
                    da_next    = DIV_A_W'({midm_reg, 15'b0});
                    db_next    = DIV_B_W'(rms_reg);
                    state_next = ST_DBAND;
                end
            end
            ST_DBAND:
            begin
                if (div_done)
                begin
                    bp_next    = (div_q > DIV_A_W'(Q15_ONE)) ? Q15_ONE : div_q[15:0];
                    state_next = ST_MULP;
                end
            end
            ST_MULP:
            begin
                da_next    = DIV_A_W'(pprod);
                state_next = ST_DP;
            end
            ST_DP:
            begin
                p_next     = pscaled[35:20];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    prob_next = vnew;
                    // run counters with hysteresis
                    if (vnew > OPEN_THRESH)
                    begin
                        open_next  = open_reg + 1'b1;
                        close_next = '0;
                        if (open_next >= 8'(OPEN_BLOCKS))
                        begin
                            active_next = 1'b1;
                        end
                    end
                    else if (vnew <= CLOSE_THRESH)
                    begin
                        close_next = close_reg + 1'b1;
                        open_next  = '0;
                        if (close_next >= 8'(CLOSE_BLOCKS))
                        begin
                            active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        open_next  = '0;
                        close_next = '0;
                    end
                    ov_next                   = 1'b1;
                    od_next.rms_level         = rms_reg;
                    od_next.peak_level        = snap_reg.peak;
                    od_next.transient_level   = trans_reg;
                    od_next.low_band_level    = lowm_reg;
                    od_next.mid_band_level    = midm_reg;
                    od_next.high_band_level   = highm_reg;
                    od_next.noise_floor_level = fround[31:16];
                    od_next.voice_probability = vround[31:16];
                    od_next.voice_active      = active_next;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and persistent detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            go_reg     <= 1'b0;
            fast_reg   <= '0;
            slow_reg   <= '0;
            floor_reg  <= FLOOR_MIN;
            prob_reg   <= '0;
            open_reg   <= '0;
            close_reg  <= '0;
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            go_reg     <= go_next;
            fast_reg   <= fast_next;
            slow_reg   <= slow_next;
            floor_reg  <= floor_next;
            prob_reg   <= prob_next;
            open_reg   <= open_next;
            close_reg  <= close_next;
            active_reg <= active_next;
            ov_reg     <= ov_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        snap_reg  <= snap_next;
        da_reg    <= da_next;
        db_reg    <= db_next;
        sv_reg    <= sv_next;
        sr_reg    <= sr_next;
        sbit_reg  <= sbit_next;
        rms_reg   <= rms_next;
        lowm_reg  <= lowm_next;
        midm_reg  <= midm_next;
        highm_reg <= highm_next;
        trans_reg <= trans_next;
        lp_reg    <= lp_next;
        bp_reg    <= bp_next;
        p_reg     <= p_next;
        od_reg    <= od_next;
    end

endmodule

>>> design/audio_block_voice_activity_detector.sv
// top level of the block voice activity detector
// sample path: a sample is filtered, then accumulated into the block totals; a
//   block result takes up to six divisions on one shared divider plus a
//   bit-serial square root
// flow: the front takes no new sample until the last one is accumulated; a
//   two-entry queue lets the front run ahead
// reset: asynchronous active low; clears accumulators, filters, envelopes and
//   run counters, sets the noise floor to 16 and loads the register defaults
`timescale 1ns / 1ps

module audio_block_voice_activity_detector
    import abvad_pkg::*;
#(
    parameter int BLOCK_MAX    = 4096,
    parameter int OPEN_BLOCKS  = 3,
    parameter int CLOSE_BLOCKS = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // sample
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // rms_level, peak_level, transient_level, low_band_level, mid_band_level,
    // high_band_level, noise_floor_level, voice_probability, voice_active
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             cfg_wen,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    cfg_t    cfg_reg;
    logic    q_full, q_push, q_empty, q_pop;
    block_t  q_in, q_out;
    result_t res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_split_coef  <= 16'd2458;
            cfg_reg.mid_split_coef  <= 16'd16384;
            cfg_reg.fast_attack     <= 16'd32768;
            cfg_reg.fast_release    <= 16'd13107;
            cfg_reg.slow_attack     <= 16'd3277;
            cfg_reg.slow_release    <= 16'd1311;
            cfg_reg.floor_fall_rate <= 16'd19661;
            cfg_reg.floor_rise_rate <= 16'd66;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LOW_SPLIT:    cfg_reg.low_split_coef  <= cfg_data;
                CFG_MID_SPLIT:    cfg_reg.mid_split_coef  <= cfg_data;
                CFG_FAST_ATTACK:  cfg_reg.fast_attack     <= cfg_data;
                CFG_FAST_RELEASE: cfg_reg.fast_release    <= cfg_data;
                CFG_SLOW_ATTACK:  cfg_reg.slow_attack     <= cfg_data;
                CFG_SLOW_RELEASE: cfg_reg.slow_release    <= cfg_data;
                CFG_FLOOR_FALL:   cfg_reg.floor_fall_rate <= cfg_data;
                CFG_FLOOR_RISE:   cfg_reg.floor_rise_rate <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    abvad_front #(.BLOCK_MAX(BLOCK_MAX)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    abvad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    abvad_back #(.OPEN_BLOCKS(OPEN_BLOCKS), .CLOSE_BLOCKS(CLOSE_BLOCKS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_out),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {7'b0, res};

endmodule

>>> design/abvad_checker.sv
// port-level assertions for the voice activity detector, bound to the top
`timescale 1ns / 1ps

module abvad_checker
    import abvad_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // no result while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // noise floor never below its minimum
    a_floor_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[111:96] >= 16'd16)
        else $error("noise floor below minimum");

    // q15 levels stay at or below full scale
    a_q15_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] <= Q15_ONE) && (m_axis_tdata[47:32] <= Q15_ONE)
                          && (m_axis_tdata[127:112] <= Q15_ONE))
        else $error("level above full scale");

endmodule

bind audio_block_voice_activity_detector abvad_checker u_abvad_checker (.*);
